[rtl/core/eeuc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eeuc_pkg
// Shared widths and state codes for the extended Euclid modular inverse core.
// ----------------------------------------------------------------------------
package eeuc_pkg;

    localparam int OPERAND_WIDTH = 32;
    localparam int COEF_WIDTH    = OPERAND_WIDTH + 1;
    localparam int CNT_WIDTH     = $clog2(OPERAND_WIDTH);

    localparam logic [CNT_WIDTH-1:0] CNT_LAST = CNT_WIDTH'(OPERAND_WIDTH - 1);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_DIV  = 5'b00010,
        ST_UPD  = 5'b00100,
        ST_FIN  = 5'b01000,
        ST_RED  = 5'b10000
    } state_t;

endpackage

`default_nettype wire

[rtl/core/extended_euclid_modular_inverse_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// extended_euclid_modular_inverse_core
// Extended Euclidean algorithm with bit-serial restoring division; gives gcd,
// Bezout coefficients and the inverse of the second operand modulo the first.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+---------------------------------------------
//  in      | in_valid / in_stall | first_operand, second_operand
//  out     | out_valid/out_stall | gcd_value, coef_first, coef_second,
//          |                     | has_inverse, inverse_value
//
//  Each Euclid step gives one quotient bit per cycle from the shared
//  divide/multiply-accumulate datapath, then an update state. An item needs
//  at most 46 steps for 32-bit operands. One item is worked on at a time.
//  The result sits in an output register, so a new item is taken while it
//  waits; a stalled output only holds the core once the next result is ready.
//  rst_n clears control state only.
// ----------------------------------------------------------------------------
module extended_euclid_modular_inverse_core
(
    input  wire                                        clk,
    input  wire                                        rst_n,

    input  wire                                        in_valid,
    output logic                                       in_stall,
    input  wire         [eeuc_pkg::OPERAND_WIDTH-1:0]  first_operand,
    input  wire         [eeuc_pkg::OPERAND_WIDTH-1:0]  second_operand,

    output logic                                       out_valid,
    input  wire                                        out_stall,
    output logic        [eeuc_pkg::OPERAND_WIDTH-1:0]  gcd_value,
    output logic signed [eeuc_pkg::COEF_WIDTH-1:0]     coef_first,
    output logic signed [eeuc_pkg::COEF_WIDTH-1:0]     coef_second,
    output logic                                       has_inverse,
    output logic        [eeuc_pkg::OPERAND_WIDTH-1:0]  inverse_value
);

    localparam int W  = eeuc_pkg::OPERAND_WIDTH;
    localparam int CW = eeuc_pkg::COEF_WIDTH;

    eeuc_pkg::state_t state_reg, state_next;
    logic [eeuc_pkg::CNT_WIDTH-1:0] cnt_reg;
    logic out_valid_reg;

    // remainder pair, coefficient pairs
    logic [W-1:0]  m_reg, r0_reg, r1_reg;
    logic [CW-1:0] cu_reg, cv_reg, nu_reg, nv_reg;
    // division shift registers and product accumulators
    logic [W-1:0]  quo_reg, rem_reg;
    logic [CW-1:0] acc_u_reg, acc_v_reg;
    // reduced inverse, computed in ST_FIN ahead of the output load in ST_RED
    logic [W-1:0]  inv_reg;
    logic          inv_ok_reg;

    logic [W-1:0]  gcd_reg, inv_out_reg;
    logic [CW-1:0] coef_first_reg, coef_second_reg;
    logic          has_inv_reg;

    logic [W:0]    trial;
    logic [W-1:0]  diff;
    logic          qbit;
    logic [W-1:0]  rem_next;
    logic [CW-1:0] acc_u_next, acc_v_next;
    logic          out_free;
    logic          in_xfer;

    logic [W-1:0]  inv_sum;
    logic [W-1:0]  inv_next;

    assign in_xfer  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != eeuc_pkg::ST_IDLE);

    // one restoring-division step; the remainder stays below the divisor
    assign trial    = {rem_reg, quo_reg[W-1]};
    assign diff     = trial[W-1:0] - r1_reg;
    assign qbit     = (trial >= {1'b0, r1_reg});
    assign rem_next = qbit ? diff : trial[W-1:0];

    // Horner accumulation of q * next coefficient, MSB of q first
    assign acc_u_next = {acc_u_reg[CW-2:0], 1'b0} + (qbit ? nu_reg : {CW{1'b0}});
    assign acc_v_next = {acc_v_reg[CW-2:0], 1'b0} + (qbit ? nv_reg : {CW{1'b0}});

    // |cv| <= modulus, so one add or subtract brings it into range
    assign inv_sum = cv_reg[W-1:0] + m_reg;
    always_comb
    begin
        if (cv_reg[CW-1])
        begin
            inv_next = inv_sum;
        end
        else if (cv_reg >= {1'b0, m_reg})
        begin
            inv_next = cv_reg[W-1:0] - m_reg;
        end
        else
        begin
            inv_next = cv_reg[W-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            eeuc_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = (second_operand == {W{1'b0}}) ? eeuc_pkg::ST_FIN
                                                               : eeuc_pkg::ST_DIV;
                end
            end
            eeuc_pkg::ST_DIV:
            begin
                if (cnt_reg == {eeuc_pkg::CNT_WIDTH{1'b0}})
                begin
                    state_next = eeuc_pkg::ST_UPD;
                end
            end
            eeuc_pkg::ST_UPD:
            begin
                state_next = (rem_reg == {W{1'b0}}) ? eeuc_pkg::ST_FIN : eeuc_pkg::ST_DIV;
            end
            eeuc_pkg::ST_FIN:
            begin
                state_next = eeuc_pkg::ST_RED;
            end
            eeuc_pkg::ST_RED:
            begin
                if (out_free)
                begin
                    state_next = eeuc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = eeuc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= eeuc_pkg::ST_IDLE;
            cnt_reg       <= eeuc_pkg::CNT_LAST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == eeuc_pkg::ST_DIV)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
            else
            begin
                cnt_reg <= eeuc_pkg::CNT_LAST;
            end
            if (state_reg == eeuc_pkg::ST_RED && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            eeuc_pkg::ST_IDLE:
            begin
                m_reg     <= first_operand;
                r0_reg    <= first_operand;
                r1_reg    <= second_operand;
                cu_reg    <= CW'(1);
                cv_reg    <= {CW{1'b0}};
                nu_reg    <= {CW{1'b0}};
                nv_reg    <= CW'(1);
                quo_reg   <= first_operand;
                rem_reg   <= {W{1'b0}};
                acc_u_reg <= {CW{1'b0}};
                acc_v_reg <= {CW{1'b0}};
            end
            eeuc_pkg::ST_DIV:
            begin
                quo_reg   <= {quo_reg[W-2:0], qbit};
                rem_reg   <= rem_next;
                acc_u_reg <= acc_u_next;
                acc_v_reg <= acc_v_next;
            end
            eeuc_pkg::ST_UPD:
            begin
                r0_reg    <= r1_reg;
                r1_reg    <= rem_reg;
                cu_reg    <= nu_reg;
                nu_reg    <= cu_reg - acc_u_reg;
                cv_reg    <= nv_reg;
                nv_reg    <= cv_reg - acc_v_reg;
                // next dividend is the current divisor
                quo_reg   <= r1_reg;
                rem_reg   <= {W{1'b0}};
                acc_u_reg <= {CW{1'b0}};
                acc_v_reg <= {CW{1'b0}};
            end
            eeuc_pkg::ST_FIN:
            begin
                inv_ok_reg <= (r0_reg == W'(1)) && (m_reg != {W{1'b0}});
                inv_reg    <= inv_next;
            end
            eeuc_pkg::ST_RED:
            begin
                if (out_free)
                begin
                    gcd_reg         <= r0_reg;
                    coef_first_reg  <= cu_reg;
                    coef_second_reg <= cv_reg;
                    has_inv_reg     <= inv_ok_reg;
                    inv_out_reg     <= inv_ok_reg ? inv_reg : {W{1'b0}};
                end
            end
            default:
            begin
                rem_reg <= {W{1'b0}};
            end
        endcase
    end

    assign out_valid     = out_valid_reg;
    assign gcd_value     = gcd_reg;
    assign coef_first    = coef_first_reg;
    assign coef_second   = coef_second_reg;
    assign has_inverse   = has_inv_reg;
    assign inverse_value = inv_out_reg;

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register not one-hot");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == eeuc_pkg::ST_DIV |-> r1_reg != {W{1'b0}})
        else $error("division by zero remainder");

    a_inv_gcd: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && has_inverse |-> gcd_value == W'(1))
        else $error("inverse flagged without unit gcd");

    a_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_inverse |-> inverse_value == {W{1'b0}})
        else $error("inverse not cleared when absent");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(gcd_value))
        else $error("result lost under stall");

endmodule

`default_nettype wire

[sim/extended_euclid_modular_inverse_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// extended_euclid_modular_inverse_core_test
// Self-checking bench for the extended Euclid core. It applies directed
// corner operands first, then random pairs over several flow-control phases.
// Every result is checked against a behavioural extended Euclid calculation.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic [eeuc_pkg::OPERAND_WIDTH-1:0] gcd;
    logic [eeuc_pkg::COEF_WIDTH-1:0]    coef_a;
    logic [eeuc_pkg::COEF_WIDTH-1:0]    coef_b;
    logic                               invertible;
    logic [eeuc_pkg::OPERAND_WIDTH-1:0] inverse;
} euclid_result_t;

class euclid_checker;
    euclid_result_t pending_results[$];
    int             mismatch_count;
    int             results_seen;

    function new();
        mismatch_count = 0;
        results_seen   = 0;
    endfunction

    // 64-bit wrap-around arithmetic; the true coefficients always fit in 33 bits
    function euclid_result_t predict_euclid(logic [eeuc_pkg::OPERAND_WIDTH-1:0] modulus,
                                            logic [eeuc_pkg::OPERAND_WIDTH-1:0] value);
        logic [63:0]    rem_a;
        logic [63:0]    rem_b;
        logic [63:0]    ua;
        logic [63:0]    va;
        logic [63:0]    ub;
        logic [63:0]    vb;
        logic [63:0]    quot;
        logic [63:0]    tmp;
        logic [63:0]    mod64;
        logic [63:0]    back;
        euclid_result_t res;
        rem_a = 64'(modulus);
        rem_b = 64'(value);
        ua    = 64'd1;
        va    = 64'd0;
        ub    = 64'd0;
        vb    = 64'd1;
        while (rem_b != 64'd0)
        begin
            quot  = rem_a / rem_b;
            tmp   = rem_a - quot * rem_b;
            rem_a = rem_b;
            rem_b = tmp;
            tmp   = ua - quot * ub;
            ua    = ub;
            ub    = tmp;
            tmp   = va - quot * vb;
            va    = vb;
            vb    = tmp;
        end
        res.gcd        = rem_a[eeuc_pkg::OPERAND_WIDTH-1:0];
        res.coef_a     = ua[eeuc_pkg::COEF_WIDTH-1:0];
        res.coef_b     = va[eeuc_pkg::COEF_WIDTH-1:0];
        res.invertible = (rem_a == 64'd1) && (modulus != '0);
        res.inverse    = '0;
        if (res.invertible)
        begin
            mod64 = 64'(modulus);
            if (va[63])
            begin
                back = (64'd0 - va) % mod64;
                tmp  = (back != 64'd0) ? mod64 - back : 64'd0;
            end
            else
            begin
                tmp = va % mod64;
            end
            res.inverse = tmp[eeuc_pkg::OPERAND_WIDTH-1:0];
        end
        return res;
    endfunction

    function void note_operands(logic [eeuc_pkg::OPERAND_WIDTH-1:0] modulus,
                                logic [eeuc_pkg::OPERAND_WIDTH-1:0] value);
        pending_results.push_back(predict_euclid(modulus, value));
    endfunction

    task report_mismatch(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task check_result(euclid_result_t got);
        euclid_result_t want;
        string          diffs;
        diffs = "";
        if (pending_results.size() == 0)
        begin
            report_mismatch($sformatf("result %0d arrived with nothing outstanding",
                                      results_seen));
        end
        else
        begin
            want = pending_results.pop_front();
            if (got.gcd !== want.gcd)
                diffs = {diffs, $sformatf(" gcd %h/%h", got.gcd, want.gcd)};
            if (got.coef_a !== want.coef_a)
                diffs = {diffs, $sformatf(" coef_first %h/%h", got.coef_a, want.coef_a)};
            if (got.coef_b !== want.coef_b)
                diffs = {diffs, $sformatf(" coef_second %h/%h", got.coef_b, want.coef_b)};
            if (got.invertible !== want.invertible)
                diffs = {diffs, $sformatf(" has_inverse %b/%b", got.invertible,
                                          want.invertible)};
            if (got.inverse !== want.inverse)
                diffs = {diffs, $sformatf(" inverse %h/%h", got.inverse, want.inverse)};
            if (diffs != "")
                report_mismatch($sformatf("result %0d (got/want):%s", results_seen, diffs));
        end
        results_seen++;
    endtask
endclass

module extended_euclid_modular_inverse_core_test;

    localparam int W            = eeuc_pkg::OPERAND_WIDTH;
    localparam int CW           = eeuc_pkg::COEF_WIDTH;
    localparam int HOLD_CYCLES  = 3000;
    localparam int DRAIN_CYCLES = 1600;
    // covers the worst item plus the long HOLD_CYCLES hold-off
    localparam int QUIET_LIMIT  = 20000;
    localparam int PHASE_ITEMS  = 86;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [W-1:0]         first_operand;
    logic [W-1:0]         second_operand;
    logic                 out_valid;
    logic                 out_stall;
    logic [W-1:0]         gcd_value;
    logic signed [CW-1:0] coef_first;
    logic signed [CW-1:0] coef_second;
    logic                 has_inverse;
    logic [W-1:0]         inverse_value;

    int send_idle_pct;
    int stall_pct;
    bit hold_req;
    int hold_left;
    int quiet_cycles;

    euclid_checker inverse_check = new();

    extended_euclid_modular_inverse_core dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .first_operand  (first_operand),
        .second_operand (second_operand),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .gcd_value      (gcd_value),
        .coef_first     (coef_first),
        .coef_second    (coef_second),
        .has_inverse    (has_inverse),
        .inverse_value  (inverse_value)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic offer_operands(input logic [W-1:0] modulus, input logic [W-1:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid       <= 1'b1;
        first_operand  <= modulus;
        second_operand <= value;
        do
            @(posedge clk);
        while (in_stall);
        inverse_check.note_operands(modulus, value);
        @(negedge clk);
    endtask

    // mostly full-width, some shortened, a few zero or tiny
    function automatic logic [W-1:0] random_operand();
        logic [W-1:0] v;
        v = W'($urandom);
        case ($urandom_range(9))
            0:       v = '0;
            1:       v = W'($urandom_range(16, 1));
            2, 3, 4: v = v >> $urandom_range(W - 1, 1);
            default: ;
        endcase
        return v;
    endfunction

    // receiver: random stalls, or a long counted hold-off on request
    initial
    begin
        out_stall = 1'b0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            inverse_check.check_result(euclid_result_t'({gcd_value, coef_first, coef_second,
                                                         has_inverse, inverse_value}));
    end

    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
        $display("FAIL");
        $finish;
    end

    initial
    begin
        logic [W-1:0] opa;
        logic [W-1:0] opb;
        int           phase;
        int           n;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        first_operand  = '0;
        second_operand = '0;
        send_idle_pct  = 0;
        stall_pct      = 0;
        hold_req       = 1'b0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // zero operands, modulus one, no inverse, widest and longest chains
        offer_operands(32'd0, 32'd0);
        offer_operands(32'd0, 32'd7);
        offer_operands(32'd0, 32'hFFFF_FFFF);
        offer_operands(32'd5, 32'd0);
        offer_operands(32'hFFFF_FFFF, 32'd0);
        offer_operands(32'd1, 32'd0);
        offer_operands(32'd1, 32'd1);
        offer_operands(32'd1, 32'hFFFF_FFFF);
        offer_operands(32'd7, 32'd3);
        offer_operands(32'd7, 32'd7);
        offer_operands(32'd12, 32'd8);
        offer_operands(32'd8, 32'd12);
        offer_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        offer_operands(32'hFFFF_FFFF, 32'hFFFF_FFFE);
        offer_operands(32'hFFFF_FFFB, 32'd3);
        offer_operands(32'd2971215073, 32'd1836311903);
        offer_operands(32'd1836311903, 32'd2971215073);
        offer_operands(32'h8000_0000, 32'h7FFF_FFFF);
        offer_operands(32'h8000_0000, 32'd2);
        offer_operands(32'd2, 32'h8000_0000);
        offer_operands(32'd65537, 32'd65536);
        offer_operands(32'd10, 32'h7FFF_FFFF);

        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 87; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 87; end
                default: begin send_idle_pct = 29; stall_pct = 29; end
            endcase
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                opa = random_operand();
                opb = random_operand();
                case ($urandom_range(15))
                    0:       opb = opa;
                    1:       opb = opa - 1'b1;
                    2:       opb = opa + 1'b1;
                    default: ;
                endcase
                offer_operands(opa, opb);
            end
            if (phase == 0)
            begin
                // output held off while the sender keeps pushing, so input backs up
                hold_req = 1'b1;
                for (n = 0; n < 6; n++)
                    offer_operands(W'($urandom), W'($urandom));
            end
            else if (phase == 1)
            begin
                in_valid <= 1'b0;
                while (inverse_check.pending_results.size() != 0)
                    @(negedge clk);
            end
        end

        in_valid <= 1'b0;
        stall_pct = 0;
        while (inverse_check.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (inverse_check.mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
